FILE: design/perot_pkg.sv
package perot_pkg;

  // fixed-point constants, Q.30
  localparam logic [30:0]        Q30_ONE   = 31'h4000_0000;
  localparam logic signed [63:0] Q30_HALF  = 64'sd536870912;

  // width of a matrix entry, signed Q2.30 with headroom
  localparam int MAT_W = 34;

  // odd sine polynomial coefficients, Q.30
  localparam logic [31:0] SIN_C11 = 32'd3864;
  localparam logic [31:0] SIN_COEF [5] = '{
    32'd172272, 32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
  };

  // configuration register indexes
  localparam logic [2:0] REG_CENTER_X     = 3'd0;
  localparam logic [2:0] REG_CENTER_Y     = 3'd1;
  localparam logic [2:0] REG_CENTER_Z     = 3'd2;
  localparam logic [2:0] REG_ANGLE_FIRST  = 3'd3;
  localparam logic [2:0] REG_ANGLE_SECOND = 3'd4;
  localparam logic [2:0] REG_ANGLE_THIRD  = 3'd5;
  localparam logic [2:0] REG_AXIS_ORDER   = 3'd6;

  // axis codes; code three acts as z
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  localparam logic [4:0] AXIS_ORDER_RST = 5'd21;

  // split axis order into {third, second, first} axis codes
  function automatic logic [5:0] axis_split(input logic [4:0] ao);
    logic [1:0] a1, a2, a3;
    logic [4:0] r;
    if (ao >= 5'd27) a3 = 2'd3;
    else if (ao >= 5'd18) a3 = 2'd2;
    else if (ao >= 5'd9) a3 = 2'd1;
    else a3 = 2'd0;
    r = ao - 5'(9 * a3);
    if (r >= 5'd6) a2 = 2'd2;
    else if (r >= 5'd3) a2 = 2'd1;
    else a2 = 2'd0;
    a1 = 2'(r - 5'(3 * a2));
    return {a3, a2, a1};
  endfunction

endpackage

FILE: design/perot_sin_pipe.sv
module perot_sin_pipe (
  input  logic               clk_i,
  input  logic [31:0]        phase_i,
  output logic signed [31:0] sin_o
);
  import perot_pkg::*;

  logic [30:0]        x_q   [7];
  logic               one_q [7];
  logic               neg_q [7];
  logic [30:0]        x2_q  [1:5];
  logic [31:0]        t_q   [2:6];
  logic signed [31:0] sin_q;

  logic [30:0]        x_d;
  logic [61:0]        sq;
  logic [62:0]        tp  [2:6];
  logic [31:0]        t_d [2:6];
  logic [62:0]        fp;
  logic [32:0]        p;
  logic [31:0]        mag;

  // fold phase into first quadrant
  always_comb begin
    if (phase_i[30]) begin
      x_d = Q30_ONE - {1'b0, phase_i[29:0]};
    end else begin
      x_d = {1'b0, phase_i[29:0]};
    end
  end

  // horner steps, one product per stage
  always_comb begin
    sq = 62'(x_q[0]) * 62'(x_q[0]);
    tp[2] = 63'(x2_q[1]) * 63'(SIN_C11);
    t_d[2] = SIN_COEF[0] - tp[2][61:30];
    for (int i = 3; i <= 6; i++) begin
      tp[i] = 63'(x2_q[i-1]) * 63'(t_q[i-1]);
      t_d[i] = SIN_COEF[i-2] - tp[i][61:30];
    end
    fp = 63'(x_q[6]) * 63'(t_q[6]);
    p = fp[62:30];
    if (one_q[6] || p > 33'(Q30_ONE)) begin
      mag = 32'(Q30_ONE);
    end else begin
      mag = p[31:0];
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    x_q[0]   <= x_d;
    one_q[0] <= x_d[30];
    neg_q[0] <= phase_i[31];
    for (int i = 1; i < 7; i++) begin
      x_q[i]   <= x_q[i-1];
      one_q[i] <= one_q[i-1];
      neg_q[i] <= neg_q[i-1];
    end
    x2_q[1] <= sq[60:30];
    for (int i = 2; i <= 5; i++) begin
      x2_q[i] <= x2_q[i-1];
    end
    for (int i = 2; i <= 6; i++) begin
      t_q[i] <= t_d[i];
    end
    sin_q <= neg_q[6] ? -$signed(mag) : $signed(mag);
  end

  assign sin_o = sin_q;

endmodule

FILE: design/point_euler_rotation_unit.sv
// Rotates one 3D point per transfer about a configured center by three
// elementary rotations (first, then second, then third) given as binary angles.
// Input channel: start with point_x/y/z_i; busy stays low, so a point can be
// transferred on every clock cycle.
// Output channel: done_o strobes for one cycle with rotated_x/y/z_o and
// saturated_o; the receiver has no way to hold results off.
// Throughput: one point per cycle, set by the fully pipelined datapath.
// The rotation matrix is built from the configuration registers by a
// free-running 13-stage pipeline (sine polynomials, two matrix products); the
// point waits in a delay line until it meets that matrix.
// Configuration: write cfg_we_i with cfg_idx_i and cfg_wdata_i while no point
// is in flight; the new setting applies from the next transfer on.
// Reset: clears the valid pipeline and sets centers and angles to zero and the
// axis order to x, y, z.
module point_euler_rotation_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [(COORD_WIDTH > ANGLE_WIDTH ? COORD_WIDTH : ANGLE_WIDTH)-1:0] cfg_wdata_i,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  output logic                   done_o,
  output logic signed [COORD_WIDTH-1:0] rotated_x_o,
  output logic signed [COORD_WIDTH-1:0] rotated_y_o,
  output logic signed [COORD_WIDTH-1:0] rotated_z_o,
  output logic                   saturated_o
);
  import perot_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int DW    = CW + 1;
  localparam int LO_W  = DW / 2;
  localparam int HI_W  = DW - LO_W;
  localparam int PH_W  = MAT_W + HI_W;
  localparam int PL_W  = MAT_W + LO_W + 1;
  localparam int SH_W  = PH_W + 2;
  localparam int SL_W  = PL_W + 2;
  localparam int ACC_W = DW + MAT_W + 4;
  localparam int RW    = ACC_W - 30;
  localparam int VW    = RW + 1;
  // point delay matching the matrix pipeline
  localparam int D_DLY = 12;
  localparam int NV    = D_DLY + 5;

  localparam logic signed [VW-1:0] SAT_HI = {{(VW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [VW-1:0] SAT_LO = {{(VW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  // configuration registers
  logic signed [CW-1:0]   ctr_q [3];
  logic [ANGLE_WIDTH-1:0] ang_q [3];
  logic [4:0]             axis_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        ctr_q[i] <= '0;
        ang_q[i] <= '0;
      end
      axis_q <= AXIS_ORDER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CENTER_X:     ctr_q[0] <= cfg_wdata_i[CW-1:0];
        REG_CENTER_Y:     ctr_q[1] <= cfg_wdata_i[CW-1:0];
        REG_CENTER_Z:     ctr_q[2] <= cfg_wdata_i[CW-1:0];
        REG_ANGLE_FIRST:  ang_q[0] <= cfg_wdata_i[ANGLE_WIDTH-1:0];
        REG_ANGLE_SECOND: ang_q[1] <= cfg_wdata_i[ANGLE_WIDTH-1:0];
        REG_ANGLE_THIRD:  ang_q[2] <= cfg_wdata_i[ANGLE_WIDTH-1:0];
        REG_AXIS_ORDER:   axis_q   <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  // sine and cosine of each angle
  logic signed [31:0] sc [6];

  for (genvar g = 0; g < 6; g++) begin : g_sin
    logic [31:0] phase;
    assign phase = (32'(ang_q[g/2]) << (32 - ANGLE_WIDTH)) + ((g % 2 == 1) ? 32'h4000_0000 : 32'h0);
    perot_sin_pipe u_sin (
      .clk_i   (clk_i),
      .phase_i (phase),
      .sin_o   (sc[g])
    );
  end

  // elementary rotation matrices
  logic signed [31:0] r_d [3][3][3];
  logic signed [31:0] r_q [3][3][3];
  logic [5:0]         axes;

  always_comb begin
    axes = axis_split(axis_q);
    for (int m = 0; m < 3; m++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          r_d[m][i][j] = '0;
        end
      end
      case (axes[2*m +: 2])
        AX_X: begin
          r_d[m][0][0] = 32'(Q30_ONE);
          r_d[m][1][1] = sc[2*m+1];
          r_d[m][1][2] = -sc[2*m];
          r_d[m][2][1] = sc[2*m];
          r_d[m][2][2] = sc[2*m+1];
        end
        AX_Y: begin
          r_d[m][0][0] = sc[2*m+1];
          r_d[m][0][2] = sc[2*m];
          r_d[m][1][1] = 32'(Q30_ONE);
          r_d[m][2][0] = -sc[2*m];
          r_d[m][2][2] = sc[2*m+1];
        end
        default: begin
          r_d[m][0][0] = sc[2*m+1];
          r_d[m][0][1] = -sc[2*m];
          r_d[m][1][0] = sc[2*m];
          r_d[m][1][1] = sc[2*m+1];
          r_d[m][2][2] = 32'(Q30_ONE);
        end
      endcase
    end
  end

  // matrix products: T = R2*R1, then M = R3*T
  logic signed [63:0]      pa_q [3][3][3];
  logic signed [MAT_W-1:0] t_q  [3][3];
  logic signed [65:0]      pb_q [3][3][3];
  logic signed [MAT_W-1:0] m_q  [3][3];
  logic signed [65:0]      ta_d [3][3];
  logic signed [67:0]      ma_d [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ta_d[i][j] = 66'(pa_q[i][j][0]) + 66'(pa_q[i][j][1]) + 66'(pa_q[i][j][2])
                   + 66'(Q30_HALF);
        ma_d[i][j] = 68'(pb_q[i][j][0]) + 68'(pb_q[i][j][1]) + 68'(pb_q[i][j][2])
                   + 68'(Q30_HALF);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          pa_q[i][j][k] <= r_q[1][i][k] * r_q[0][k][j];
          pb_q[i][j][k] <= 66'(r_q[2][i][k]) * 66'(t_q[k][j]);
        end
        t_q[i][j] <= MAT_W'(ta_d[i][j] >>> 30);
        m_q[i][j] <= MAT_W'(ma_d[i][j] >>> 30);
      end
    end
  end

  // point path: valid line
  logic [NV-1:0] vld_q;
  logic          accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NV-2:0], accept};
    end
  end

  // point capture, offset from center and delay line
  logic signed [CW-1:0] pt_q [3];
  logic signed [DW-1:0] d_q  [D_DLY][3];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pt_q[0] <= point_x_i;
      pt_q[1] <= point_y_i;
      pt_q[2] <= point_z_i;
    end
    for (int j = 0; j < 3; j++) begin
      d_q[0][j] <= DW'(pt_q[j]) - DW'(ctr_q[j]);
      for (int s = 1; s < D_DLY; s++) begin
        d_q[s][j] <= d_q[s-1][j];
      end
    end
  end

  // matrix times offset, split into high and low partial products
  logic signed [PH_W-1:0]  ph_q [3][3];
  logic signed [PL_W-1:0]  pl_q [3][3];
  logic signed [SH_W-1:0]  hi_q [3];
  logic signed [SL_W-1:0]  lo_q [3];
  logic signed [RW-1:0]    rr_q [3];
  logic signed [ACC_W-1:0] acc_d [3];
  logic signed [VW-1:0]    v_d  [3];
  logic signed [CW-1:0]    out_q [3];
  logic                    sat_q;
  logic                    sat_d;

  always_comb begin
    sat_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc_d[i] = (ACC_W'(hi_q[i]) <<< LO_W) + ACC_W'(lo_q[i]) + ACC_W'(Q30_HALF);
      v_d[i] = VW'(rr_q[i]) + VW'(ctr_q[i]);
      if (v_d[i] > SAT_HI) begin
        v_d[i] = SAT_HI;
        sat_d  = 1'b1;
      end else if (v_d[i] < SAT_LO) begin
        v_d[i] = SAT_LO;
        sat_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ph_q[i][j] <= PH_W'(m_q[i][j]) * PH_W'($signed(d_q[D_DLY-1][j][DW-1:LO_W]));
        pl_q[i][j] <= PL_W'(m_q[i][j])
                    * PL_W'($signed({1'b0, d_q[D_DLY-1][j][LO_W-1:0]}));
      end
      hi_q[i]  <= SH_W'(ph_q[i][0]) + SH_W'(ph_q[i][1]) + SH_W'(ph_q[i][2]);
      lo_q[i]  <= SL_W'(pl_q[i][0]) + SL_W'(pl_q[i][1]) + SL_W'(pl_q[i][2]);
      rr_q[i]  <= RW'(acc_d[i] >>> 30);
      out_q[i] <= v_d[i][CW-1:0];
    end
    sat_q <= sat_d;
  end

  assign done_o      = vld_q[NV-1];
  assign rotated_x_o = out_q[0];
  assign rotated_y_o = out_q[1];
  assign rotated_z_o = out_q[2];
  assign saturated_o = sat_q;

  // result strobe follows a transfer by the fixed latency
  a_done_after_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, NV))
    else $error("result strobe without matching transfer");

  a_start_gives_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##NV done_o)
    else $error("transfer lost in pipeline");

  // a clipped result has a coordinate at a limit
  a_sat_at_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && saturated_o |->
      rotated_x_o == SAT_HI[CW-1:0] || rotated_x_o == SAT_LO[CW-1:0] ||
      rotated_y_o == SAT_HI[CW-1:0] || rotated_y_o == SAT_LO[CW-1:0] ||
      rotated_z_o == SAT_HI[CW-1:0] || rotated_z_o == SAT_LO[CW-1:0])
    else $error("saturation flag without clipped coordinate");

endmodule

FILE: bench/point_euler_rotation_unit_tb.sv
module point_euler_rotation_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import perot_pkg::*;

  localparam int CW = 32;
  localparam int AW = 16;
  localparam int PIPE_CYCLES = 24;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1550;
  // index that names no register
  localparam logic [2:0] REG_NONE = 3'd7;

  typedef longint mat3_t [0:2][0:2];

  typedef struct packed {
    logic [CW-1:0] rx;
    logic [CW-1:0] ry;
    logic [CW-1:0] rz;
    logic          sat;
  } rot_result_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [2:0]    cfg_idx_i = REG_CENTER_X;
  logic [CW-1:0] cfg_wdata_i = '0;
  logic          start = 1'b0;
  logic          busy;
  logic [CW-1:0] point_x_i = '0, point_y_i = '0, point_z_i = '0;
  logic          done_o;
  logic [CW-1:0] rotated_x_o, rotated_y_o, rotated_z_o;
  logic          saturated_o;

  // shadow copy of the configuration
  longint    ctr_x, ctr_y, ctr_z;
  bit [AW-1:0] ang1, ang2, ang3;
  bit [4:0]  axes;

  rot_result_t rotated_q[$];
  int        err_cnt = 0;
  int        point_cnt = 0;
  int        result_cnt = 0;
  int        cfg_cnt = 0;
  longint    cycle_cnt = 0;
  int        burst_left = 0;
  bit        gaps_on = 1'b1;

  point_euler_rotation_unit #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("simulation failed");
      $finish;
    end
  end

  // sine of a 32-bit phase, Q0.30
  function automatic longint quarter_sine(longint unsigned x);
    longint unsigned x2, t;
    if (x >= 64'd1073741824) return 64'd1073741824;
    x2 = (x * x) >> 30;
    t = 3864;
    t = 172272 - ((x2 * t) >> 30);
    t = 5026995 - ((x2 * t) >> 30);
    t = 85569306 - ((x2 * t) >> 30);
    t = 693598668 - ((x2 * t) >> 30);
    t = 1686629713 - ((x2 * t) >> 30);
    t = (x * t) >> 30;
    if (t > 64'd1073741824) t = 64'd1073741824;
    return longint'(t);
  endfunction

  function automatic longint phase_sine(bit [31:0] ph);
    longint s;
    if (ph[30]) s = quarter_sine(64'd1073741824 - {34'd0, ph[29:0]});
    else s = quarter_sine({34'd0, ph[29:0]});
    return ph[31] ? -s : s;
  endfunction

  // elementary rotation; any code other than x or y means z
  function automatic mat3_t axis_rotation(int axis, bit [AW-1:0] ang);
    mat3_t m;
    bit [31:0] ph;
    longint s, c;
    ph = {ang, 16'd0};
    s = phase_sine(ph);
    c = phase_sine(ph + 32'h4000_0000);
    foreach (m[i, j]) m[i][j] = 0;
    if (axis == AX_X) begin
      m[0][0] = 1 << 30; m[1][1] = c; m[1][2] = -s; m[2][1] = s; m[2][2] = c;
    end else if (axis == AX_Y) begin
      m[0][0] = c; m[0][2] = s; m[1][1] = 1 << 30; m[2][0] = -s; m[2][2] = c;
    end else begin
      m[0][0] = c; m[0][1] = -s; m[1][0] = s; m[1][1] = c; m[2][2] = 1 << 30;
    end
    return m;
  endfunction

  function automatic mat3_t mat_product(mat3_t a, mat3_t b);
    mat3_t r;
    longint acc;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += a[i][k] * b[k][j];
        r[i][j] = (acc + 64'sd536870912) >>> 30;
      end
    return r;
  endfunction

  // full rotation of one point about the center, with saturation
  function automatic rot_result_t rotate_point(logic [CW-1:0] px, logic [CW-1:0] py,
                                               logic [CW-1:0] pz);
    mat3_t m;
    longint d[3], c[3], v, hi, lo, dh, dl, hh, hl;
    logic [CW-1:0] o[3];
    rot_result_t r;
    r.sat = 1'b0;
    m = mat_product(axis_rotation(axes / 9, ang3),
                    mat_product(axis_rotation((axes / 3) % 3, ang2),
                                axis_rotation(axes % 3, ang1)));
    c[0] = ctr_x; c[1] = ctr_y; c[2] = ctr_z;
    d[0] = longint'(signed'(px)) - c[0];
    d[1] = longint'(signed'(py)) - c[1];
    d[2] = longint'(signed'(pz)) - c[2];
    for (int i = 0; i < 3; i++) begin
      hi = 0; lo = 0;
      for (int j = 0; j < 3; j++) begin
        dh = d[j] >>> 24;
        dl = d[j] - dh * 16777216;
        hi += dh * m[i][j];
        lo += dl * m[i][j];
      end
      hh = hi >>> 6;
      hl = hi - hh * 64;
      v = hh + ((hl * 16777216 + lo + 64'sd536870912) >>> 30) + c[i];
      if (v > 64'sd2147483647) begin v = 64'sd2147483647; r.sat = 1'b1; end
      if (v < -64'sd2147483648) begin v = -64'sd2147483648; r.sat = 1'b1; end
      o[i] = v[CW-1:0];
    end
    r.rx = o[0]; r.ry = o[1]; r.rz = o[2];
    return r;
  endfunction

  // result check
  always @(posedge clk_i) begin
    rot_result_t want;
    if (done_o) begin
      result_cnt++;
      if (rotated_q.size() == 0) begin
        $error("result with no point outstanding");
        err_cnt++;
      end else begin
        want = rotated_q.pop_front();
        if (rotated_x_o !== want.rx) begin
          $error("rotated_x: expected %h, got %h", want.rx, rotated_x_o); err_cnt++;
        end
        if (rotated_y_o !== want.ry) begin
          $error("rotated_y: expected %h, got %h", want.ry, rotated_y_o); err_cnt++;
        end
        if (rotated_z_o !== want.rz) begin
          $error("rotated_z: expected %h, got %h", want.rz, rotated_z_o); err_cnt++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated: expected %b, got %b", want.sat, saturated_o); err_cnt++;
        end
      end
    end
  end

  // one register write, after which cfg_we_i is dropped again; shadow follows the same masking
  task automatic write_reg(logic [2:0] idx, logic [CW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_cnt++;
    case (idx)
      REG_CENTER_X:     ctr_x = longint'(signed'(val));
      REG_CENTER_Y:     ctr_y = longint'(signed'(val));
      REG_CENTER_Z:     ctr_z = longint'(signed'(val));
      REG_ANGLE_FIRST:  ang1 = val[AW-1:0];
      REG_ANGLE_SECOND: ang2 = val[AW-1:0];
      REG_ANGLE_THIRD:  ang3 = val[AW-1:0];
      REG_AXIS_ORDER:   axes = val[4:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // one point transfer, then maybe a gap
  task automatic send_point(logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] pz);
    bit b;
    int gap;
    start <= 1'b1;
    point_x_i <= px;
    point_y_i <= py;
    point_z_i <= pz;
    do begin
      @(negedge clk_i);
      b = busy;
      @(posedge clk_i);
    end while (b);
    rotated_q.push_back(rotate_point(px, py, pz));
    point_cnt++;
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // let every outstanding point come back, then idle
  task automatic drain;
    start <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2, 3: return CW'(int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CW-1:0] rand_angle();
    logic [15:0] a;
    case ($urandom_range(0, 5))
      0: a = 16'h0000;
      1: a = 16'h4000;
      2: a = 16'h8000;
      3: a = 16'h7fff;
      default: a = 16'($urandom());
    endcase
    return {16'($urandom()), a};
  endfunction

  task automatic test_reset_identity;
    send_point('0, '0, '0);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    drain();
  endtask

  // extremes of angles, centers and points; saturation
  task automatic test_directed;
    write_reg(REG_ANGLE_FIRST, 32'h0000_4000);
    write_reg(REG_ANGLE_SECOND, 32'h0000_8000);
    write_reg(REG_ANGLE_THIRD, 32'h0000_7fff);
    write_reg(REG_CENTER_X, 32'h8000_0000);
    write_reg(REG_CENTER_Y, 32'h7fff_ffff);
    write_reg(REG_CENTER_Z, 32'h0001_8000);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point('0, 32'hffff_ffff, 32'h0000_0001);
    send_point(32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678);
    drain();
    // single-axis rotations about each axis
    write_reg(REG_CENTER_X, '0);
    write_reg(REG_CENTER_Y, '0);
    write_reg(REG_CENTER_Z, '0);
    write_reg(REG_ANGLE_SECOND, '0);
    write_reg(REG_ANGLE_THIRD, '0);
    write_reg(REG_ANGLE_FIRST, 32'h0000_2000);
    for (int a = 0; a < 3; a++) begin
      drain();
      write_reg(REG_AXIS_ORDER, 32'(a));
      send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
      send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    end
    drain();
    // axis code three acts as z; wide write data ignored above the width
    write_reg(REG_AXIS_ORDER, 32'hffff_ffe0 | 32'd31);
    write_reg(REG_ANGLE_THIRD, 32'habcd_c000);
    write_reg(REG_ANGLE_FIRST, 32'h1234_8000);
    send_point(32'h0010_0000, 32'hfff0_0000, 32'h0000_8000);
    send_point(32'h8000_0000, 32'h0000_0000, 32'h7fff_ffff);
    drain();
    // unknown register index has no effect
    write_reg(REG_NONE, 32'hdead_beef);
    send_point(32'h0003_0000, 32'h0004_0000, 32'h0005_0000);
    drain();
  endtask

  // random settings, each phase with random points
  task automatic test_random;
    int per_phase;
    per_phase = RANDOM_ITEMS / 12;
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_CENTER_X, (ph == 0) ? 32'h7fff_ffff : rand_coord());
      write_reg(REG_CENTER_Y, (ph == 0) ? 32'h8000_0000 : rand_coord());
      write_reg(REG_CENTER_Z, rand_coord());
      write_reg(REG_ANGLE_FIRST, rand_angle());
      write_reg(REG_ANGLE_SECOND, rand_angle());
      write_reg(REG_ANGLE_THIRD, rand_angle());
      write_reg(REG_AXIS_ORDER, (ph == 1) ? 32'd0 : {27'($urandom()), 5'($urandom())});
      if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, $urandom());
      gaps_on = (ph % 3 != 2);
      for (int n = 0; n < per_phase; n++)
        send_point(rand_coord(), rand_coord(), rand_coord());
      drain();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    ctr_x = 0; ctr_y = 0; ctr_z = 0;
    ang1 = '0; ang2 = '0; ang3 = '0;
    axes = AXIS_ORDER_RST;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_identity();
    test_directed();
    test_random();
    $display("%0d points rotated, %0d results checked, %0d register writes",
             point_cnt, result_cnt, cfg_cnt);
    if (err_cnt == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

FILE: sim.f
design/perot_pkg.sv
design/perot_sin_pipe.sv
design/point_euler_rotation_unit.sv
bench/point_euler_rotation_unit_tb.sv
